### design/assert_macros.svh
// Assertion helpers shared by the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define GFE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define GFE_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### design/gfe_pkg.sv
package gfe_pkg;

	// Low byte of the field polynomial x^8+x^4+x^3+x^2+1
	localparam logic [7:0] GF_POLY_LOW = 8'h1d;

	// Input word function codes
	localparam logic FUNC_COEF = 1'b0;
	localparam logic FUNC_DATA = 1'b1;

	// Register map, index taken from paddr[2]
	localparam int PADDR_W = 3;
	localparam logic REG_DATA_SHARDS = 1'b0;
	localparam logic REG_PARITY_SHARDS = 1'b1;

	// Reset values of the configuration registers
	localparam logic [5:0] DATA_SHARDS_RST = 6'd4;
	localparam logic [4:0] PARITY_SHARDS_RST = 5'd2;

	// Hard cap on parity rows per byte position
	localparam int RESULT_LIMIT = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_FINISH
	} state_t;

	// GF(2^8) multiply, shift-and-add over the eight bits of b
	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] p;
		x = a;
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				p = p ^ x;
			end
			x = x[7] ? ({x[6:0], 1'b0} ^ GF_POLY_LOW) : {x[6:0], 1'b0};
		end
		return p;
	endfunction

endpackage

### design/gfe_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module gfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/gf256_erasure_parity_encoder_top.sv
// Coefficient words and ignored data words are taken while idle and leave the block idle.
// A data word occupies the block from accept until its last parity row leaves stage 1:
// after accept, one coefficient/accumulator memory read per parity row.
// On the last shard, each parity row goes from the memory reads through stage 1 to the output register.
// Reset: data_shards = 4, parity_shards = 2, accumulators read as zero (valid bits);
// the coefficient memory is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module gf256_erasure_parity_encoder_top #(
	parameter int MAX_DATA_SHARDS = 32,
	parameter int MAX_PARITY_SHARDS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// config port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gfe_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// input words
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic [3:0]                  row_index,
	input  logic [4:0]                  shard_index,
	input  logic [7:0]                  value,
	// result words
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [3:0]                  parity_index,
	output logic [7:0]                  parity_byte,
	output logic                        last
);

	localparam int NPR = (MAX_PARITY_SHARDS < gfe_pkg::RESULT_LIMIT) ?
		MAX_PARITY_SHARDS : gfe_pkg::RESULT_LIMIT;
	localparam int RW = (NPR > 1) ? $clog2(NPR) : 1;
	localparam int SW = (MAX_DATA_SHARDS > 1) ? $clog2(MAX_DATA_SHARDS) : 1;
	localparam int ROWS = 1 << RW;
	localparam int CDEPTH = ROWS * (1 << SW);
	localparam logic [7:0] MAXD8 = 8'(MAX_DATA_SHARDS);
	localparam logic [7:0] MAXP8 = 8'(MAX_PARITY_SHARDS);
	localparam logic [4:0] NPR5 = 5'(NPR);

	gfe_pkg::state_t state_q, state_d;

	logic [5:0]      data_shards_q;
	logic [4:0]      parity_shards_q;
	logic [SW-1:0]   shard_q;
	logic [7:0]      value_q;
	logic            first_q;
	logic            emit_q;
	logic [RW-1:0]   rlast_q;
	logic [RW-1:0]   row_q;
	logic            valid_s1;
	logic [RW-1:0]   row_s1;
	logic [ROWS-1:0] acc_vld_q;
	logic            out_valid_q;
	logic [3:0]      parity_index_q;
	logic [7:0]      parity_byte_q;
	logic            last_q;

	logic [7:0]      row8, shard8, k_eff;
	logic [4:0]      r_eff, rlast5;
	logic            in_fire, coef_we, start, issuing, s1_fire, cfg_we;
	logic [7:0]      coef_rdata, acc_rdata, acc_old, prod, acc_new;

	// config registers
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_shards_q <= gfe_pkg::DATA_SHARDS_RST;
			parity_shards_q <= gfe_pkg::PARITY_SHARDS_RST;
		end else if (cfg_we) begin
			unique case (paddr[2])
				gfe_pkg::REG_DATA_SHARDS: data_shards_q <= pwdata[5:0];
				gfe_pkg::REG_PARITY_SHARDS: parity_shards_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			gfe_pkg::REG_DATA_SHARDS: prdata = {26'd0, data_shards_q};
			gfe_pkg::REG_PARITY_SHARDS: prdata = {27'd0, parity_shards_q};
			default: prdata = '0;
		endcase
	end

	// effective k and r: zero is raised to 1, larger values saturate at the maximum
	always_comb begin
		if (data_shards_q == 6'd0) begin
			k_eff = 8'd1;
		end else if ({2'b00, data_shards_q} > MAXD8) begin
			k_eff = MAXD8;
		end else begin
			k_eff = {2'b00, data_shards_q};
		end
		if (parity_shards_q == 5'd0) begin
			r_eff = 5'd1;
		end else if (parity_shards_q > NPR5) begin
			r_eff = NPR5;
		end else begin
			r_eff = parity_shards_q;
		end
	end
	assign rlast5 = r_eff - 5'd1;

	// input decode
	assign row8 = {4'd0, row_index};
	assign shard8 = {3'd0, shard_index};
	assign in_ready = (state_q == gfe_pkg::ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign coef_we = in_fire && (func == gfe_pkg::FUNC_COEF) && (row8 < MAXP8) &&
		(shard8 < MAXD8);
	assign start = in_fire && (func == gfe_pkg::FUNC_DATA) && (shard8 < k_eff);

	// row issue and stage 1 handshake
	assign s1_fire = valid_s1 && (!emit_q || !out_valid_q || out_ready);
	assign issuing = (state_q == gfe_pkg::ST_ISSUE) && (!valid_s1 || s1_fire);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gfe_pkg::ST_IDLE: begin
				if (start) state_d = gfe_pkg::ST_ISSUE;
			end
			gfe_pkg::ST_ISSUE: begin
				if (issuing && (row_q == rlast_q)) state_d = gfe_pkg::ST_FINISH;
			end
			gfe_pkg::ST_FINISH: begin
				if (s1_fire) state_d = gfe_pkg::ST_IDLE;
			end
			default: state_d = gfe_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gfe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// latch the data word
	always_ff @(posedge clk) begin
		if (start) begin
			shard_q <= shard8[SW-1:0];
			value_q <= value;
			first_q <= (shard_index == 5'd0);
			emit_q <= (shard8 == (k_eff - 8'd1));
			rlast_q <= rlast5[RW-1:0];
		end
	end

	// row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (start) begin
			row_q <= '0;
		end else if (issuing) begin
			row_q <= row_q + 1'b1;
		end
	end

	// stage 1 valid and row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issuing) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issuing) begin
			row_s1 <= row_q;
		end
	end

	// coefficient store, address {row, shard}
	gfe_ram #(
		.WIDTH(8),
		.DEPTH(CDEPTH)
	) u_coef_ram (
		.clk  (clk),
		.we   (coef_we),
		.waddr({row8[RW-1:0], shard8[SW-1:0]}),
		.wdata(value),
		.re   (issuing),
		.raddr({row_q, shard_q}),
		.rdata(coef_rdata)
	);

	// parity accumulators
	gfe_ram #(
		.WIDTH(8),
		.DEPTH(ROWS)
	) u_acc_ram (
		.clk  (clk),
		.we   (s1_fire),
		.waddr(row_s1),
		.wdata(acc_new),
		.re   (issuing),
		.raddr(row_q),
		.rdata(acc_rdata)
	);

	// unwritten accumulators read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q <= '0;
		end else if (s1_fire) begin
			acc_vld_q[row_s1] <= 1'b1;
		end
	end

	// multiply-accumulate
	assign acc_old = acc_vld_q[row_s1] ? acc_rdata : 8'd0;
	assign prod = gfe_pkg::gf_mul(coef_rdata, value_q);
	assign acc_new = first_q ? prod : (acc_old ^ prod);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && emit_q) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit_q) begin
			parity_index_q <= 4'(row_s1);
			parity_byte_q <= acc_new;
			last_q <= (row_s1 == rlast_q);
		end
	end

	assign out_valid = out_valid_q;
	assign parity_index = parity_index_q;
	assign parity_byte = parity_byte_q;
	assign last = last_q;

	// checks
	`GFE_ASSERT(a_s1_hold, valid_s1 && !s1_fire |=> valid_s1 && $stable(row_s1), "stage 1 row changed while stalled")
	`GFE_ASSERT(a_idle_empty, in_ready |-> !valid_s1, "input taken with a row still in flight")
	`GFE_ASSERT_NEVER(a_out_overwrite, s1_fire && emit_q && out_valid_q && !out_ready, "result word overwritten")
	`GFE_ASSERT_NEVER(a_coef_rw, coef_we && issuing, "coefficient write during row issue")

endmodule
